// ===== rtl/iopf_pkg.sv =====
package iopf_pkg;

   localparam logic [7:0] PORT_B_DIR  = 8'hF0;
   localparam logic [7:0] PORT_B_SEL  = 8'hF1;
   localparam logic [7:0] PORT_B_DATA = 8'hF2;
   localparam logic [7:0] PORT_C_CTRL = 8'hF3;
   localparam logic [7:0] PORT_C_DATA = 8'hF4;
   localparam logic [7:0] PORT_KEY    = 8'hEF;
   localparam logic [7:0] PORT_GPO_A  = 8'hEE;
   localparam logic [7:0] MASK_B      = 8'h77;
   localparam logic [2:0] MASK_C      = 3'h7;
   localparam int         PORT_COUNT  = 256;
   localparam int         ADDR_W      = $clog2(PORT_COUNT);

   typedef struct packed {
      logic [7:0] addr;
      logic [7:0] value;
   } iopf_note_type;

   typedef struct packed {
      logic       hit;
      logic [7:0] value;
   } iopf_local_rd_type;

   // Ports held in flops next to the GPIO logic rather than in the port memory
   function automatic logic is_local_port(input logic [7:0] addr);
      logic hit;
      hit = addr inside {PORT_B_DIR, PORT_B_SEL, PORT_B_DATA, PORT_C_CTRL, PORT_C_DATA,
                         PORT_KEY};
      return hit;
   endfunction

endpackage

// ===== rtl/iopf_mem.sv =====
module iopf_mem
   import iopf_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              wr_en,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] addr,
   input  logic [7:0]        wr_data,
   output logic [7:0]        rd_data
);

   logic [7:0]            store_ff [PORT_COUNT];
   logic [PORT_COUNT-1:0] valid_ff;
   logic [PORT_COUNT-1:0] valid_in;
   logic [7:0]            rd_data_ff;
   logic                  rd_vld_ff;

   always_comb begin
      valid_in = valid_ff;
      if (wr_en) begin
         valid_in[addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= store_ff[addr];
         rd_vld_ff  <= valid_ff[addr];
      end
   end

   // never-written entries read as zero
   assign rd_data = rd_vld_ff ? rd_data_ff : 8'h00;

endmodule

// ===== rtl/iopf_gpio.sv =====
module iopf_gpio
   import iopf_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              wr_en,
   input  logic [7:0]        addr,
   input  logic [7:0]        data,
   input  logic [7:0]        bpins,
   input  logic [2:0]        cpins,
   output iopf_note_type     note,
   output iopf_local_rd_type local_rd
);

   logic [7:0] f0_ff, f0_in;
   logic [7:0] f1_ff, f1_in;
   logic [7:0] f2_ff, f2_in;
   logic [7:0] f3_ff, f3_in;
   logic [2:0] f4_ff, f4_in;
   logic [7:0] ef_ff, ef_in;
   logic [7:0] blatch_ff, blatch_in;
   logic [2:0] clatch_ff, clatch_in;

   logic [7:0] dir, sel, bl, ctrl, b_cpu;
   logic [2:0] cl, c_drive, c_cpu;
   logic       b_grp, c_grp;

   always_comb begin
      dir  = f0_ff;
      sel  = f1_ff;
      bl   = blatch_ff;
      ctrl = f3_ff;
      cl   = clatch_ff;
      case (addr)
         PORT_B_DIR:  dir  = data & MASK_B;
         PORT_B_SEL:  sel  = data & MASK_B;
         PORT_B_DATA: bl   = data;
         PORT_C_CTRL: ctrl = data & MASK_B;
         PORT_C_DATA: cl   = data[2:0] & MASK_C;
         default: ;
      endcase
      b_grp   = addr inside {PORT_B_DIR, PORT_B_SEL, PORT_B_DATA};
      c_grp   = addr inside {PORT_C_CTRL, PORT_C_DATA};
      b_cpu   = (bpins & sel) | (bl & dir & ~sel & MASK_B);
      c_drive = cl & ctrl[2:0] & ~ctrl[6:4];
      c_cpu   = (cpins & ctrl[6:4]) | c_drive;

      note.addr  = addr;
      note.value = data;
      if (b_grp) begin
         note.addr  = PORT_B_DATA;
         note.value = b_cpu & MASK_B & ~ef_ff;
      end else if (c_grp) begin
         note.addr  = PORT_C_DATA;
         note.value = {5'b0, c_drive};
      end else if (addr == PORT_GPO_A) begin
         note.value = {data[7:3], data[2] & data[3], data[1:0]};
      end

      f0_in     = wr_en ? dir : f0_ff;
      f1_in     = wr_en ? sel : f1_ff;
      f3_in     = wr_en ? ctrl : f3_ff;
      blatch_in = wr_en ? bl : blatch_ff;
      clatch_in = wr_en ? cl : clatch_ff;
      f2_in     = (wr_en && b_grp) ? b_cpu : f2_ff;
      f4_in     = (wr_en && c_grp) ? c_cpu : f4_ff;
      ef_in     = (wr_en && addr == PORT_KEY) ? data : ef_ff;

      local_rd.hit = is_local_port(addr);
      case (addr)
         PORT_B_DIR:  local_rd.value = f0_ff;
         PORT_B_SEL:  local_rd.value = f1_ff;
         PORT_B_DATA: local_rd.value = f2_ff;
         PORT_C_CTRL: local_rd.value = f3_ff;
         PORT_C_DATA: local_rd.value = {5'b0, f4_ff};
         PORT_KEY:    local_rd.value = ef_ff;
         default:     local_rd.value = 8'h00;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f0_ff     <= '0;
         f1_ff     <= '0;
         f2_ff     <= '0;
         f3_ff     <= '0;
         f4_ff     <= '0;
         ef_ff     <= '0;
         blatch_ff <= '0;
         clatch_ff <= '0;
      end else begin
         f0_ff     <= f0_in;
         f1_ff     <= f1_in;
         f2_ff     <= f2_in;
         f3_ff     <= f3_in;
         f4_ff     <= f4_in;
         ef_ff     <= ef_in;
         blatch_ff <= blatch_in;
         clatch_ff <= clatch_in;
      end
   end

endmodule

// ===== rtl/io_port_file_with_gpio_latches.sv =====
// channel | direction | fields
// req     | in        | op, port_addr, write_data, gpio_b_pins, gpio_c_pins
// rsp     | out       | read_data, notify_valid, notify_addr, notify_value
//
// One transaction per cycle unless a stalled response holds the pipe; each access passes
// through the port memory's registered read and then the response register to rsp_valid.
// Reset (synchronous) clears the GPIO flops and the 256 memory valid bits at once.
// A stalled response holds the pipe; req_stall follows rsp_valid & rsp_stall.
module io_port_file_with_gpio_latches
   import iopf_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic       req_op,
   input  logic [7:0] req_port_addr,
   input  logic [7:0] req_write_data,
   input  logic [7:0] req_gpio_b_pins,
   input  logic [2:0] req_gpio_c_pins,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_read_data,
   output logic       rsp_notify_valid,
   output logic [7:0] rsp_notify_addr,
   output logic [7:0] rsp_notify_value
);

   logic              advance, accept, wr_en, mem_wr;
   logic [7:0]        mem_rdata;
   iopf_note_type     note;
   iopf_local_rd_type local_rd;

   logic              p1_valid_ff, p1_valid_in;
   logic              p1_write_ff;
   iopf_note_type     p1_note_ff;
   iopf_local_rd_type p1_local_ff;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [7:0]        rsp_read_ff, rsp_read_in;
   logic              rsp_nvalid_ff, rsp_nvalid_in;
   iopf_note_type     rsp_note_ff, rsp_note_in;

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !advance;
   assign accept    = req_valid && advance;
   assign wr_en     = accept && req_op;
   assign mem_wr    = wr_en && !is_local_port(req_port_addr);

   iopf_mem u_mem (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (mem_wr),
      .rd_en   (accept),
      .addr    (req_port_addr[ADDR_W-1:0]),
      .wr_data (req_write_data),
      .rd_data (mem_rdata)
   );

   iopf_gpio u_gpio (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (wr_en),
      .addr     (req_port_addr),
      .data     (req_write_data),
      .bpins    (req_gpio_b_pins),
      .cpins    (req_gpio_c_pins),
      .note     (note),
      .local_rd (local_rd)
   );

   always_comb begin
      p1_valid_in   = advance ? accept : p1_valid_ff;
      rsp_valid_in  = advance ? p1_valid_ff : rsp_valid_ff;
      rsp_nvalid_in = p1_write_ff;
      rsp_note_in   = p1_write_ff ? p1_note_ff : '0;
      if (p1_write_ff) begin
         rsp_read_in = 8'h00;
      end else if (p1_local_ff.hit) begin
         rsp_read_in = p1_local_ff.value;
      end else begin
         rsp_read_in = mem_rdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         p1_valid_ff  <= p1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         p1_write_ff <= req_op;
         p1_note_ff  <= note;
         p1_local_ff <= local_rd;
      end
      if (advance && p1_valid_ff) begin
         rsp_read_ff   <= rsp_read_in;
         rsp_nvalid_ff <= rsp_nvalid_in;
         rsp_note_ff   <= rsp_note_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_read_data    = rsp_read_ff;
   assign rsp_notify_valid = rsp_nvalid_ff;
   assign rsp_notify_addr  = rsp_note_ff.addr;
   assign rsp_notify_value = rsp_note_ff.value;

   a_accept_fills_p1: assert property (@(posedge clock) disable iff (reset)
      accept |=> p1_valid_ff)
      else $error("accepted transaction did not reach stage one");

   a_read_no_note: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_nvalid_ff |-> rsp_note_ff.addr == 8'h00 && rsp_note_ff.value == 8'h00)
      else $error("read response carries notification data");

   a_write_no_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_nvalid_ff |-> rsp_read_ff == 8'h00)
      else $error("write response carries read data");

   a_gpio_c_width: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_nvalid_ff && rsp_note_ff.addr == PORT_C_DATA
      |-> rsp_note_ff.value[7:3] == 5'b0)
      else $error("GPIO C notification wider than three pins");

   a_gpio_b_mask: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_nvalid_ff && rsp_note_ff.addr == PORT_B_DATA
      |-> rsp_note_ff.value[7] == 1'b0 && rsp_note_ff.value[3] == 1'b0)
      else $error("GPIO B notification not masked");

endmodule

// ===== sim/iopf_test_pkg.sv =====
package iopf_test_pkg;

   localparam logic OP_READ  = 1'b0;
   localparam logic OP_WRITE = 1'b1;

endpackage

// ===== sim/iopf_port_checker.sv =====
module iopf_port_checker
   import iopf_pkg::*;
   import iopf_test_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_stall,
   input  logic       req_op,
   input  logic [7:0] req_port_addr,
   input  logic [7:0] req_write_data,
   input  logic [7:0] req_gpio_b_pins,
   input  logic [2:0] req_gpio_c_pins,
   input  logic       rsp_valid,
   input  logic       rsp_stall,
   input  logic [7:0] rsp_read_data,
   input  logic       rsp_notify_valid,
   input  logic [7:0] rsp_notify_addr,
   input  logic [7:0] rsp_notify_value,
   output int         mismatches,
   output int         outstanding
);

   typedef struct packed {
      logic [7:0] read_data;
      logic       notify_valid;
      logic [7:0] notify_addr;
      logic [7:0] notify_value;
   } iopf_reply_type;

   logic [7:0]     port_image [PORT_COUNT];
   logic [7:0]     b_out_latch;
   logic [2:0]     c_out_latch;
   iopf_reply_type access_outcomes [$];

   function automatic iopf_reply_type port_access(input logic op, input logic [7:0] addr,
                                                  input logic [7:0] data,
                                                  input logic [7:0] bpins,
                                                  input logic [2:0] cpins);
      iopf_reply_type r;
      logic [7:0]     drive_b;
      logic [7:0]     cpu_b;
      logic [3:0]     hi_c;
      logic [2:0]     drive_c;
      r = '0;
      if (op == OP_READ) begin
         r.read_data = port_image[addr];
         return r;
      end
      case (addr)
         PORT_B_DATA: b_out_latch = data;
         PORT_C_DATA: c_out_latch = data[2:0] & MASK_C;
         PORT_B_DIR, PORT_B_SEL, PORT_C_CTRL: port_image[addr] = data & MASK_B;
         default: port_image[addr] = data;
      endcase
      r.notify_valid = 1'b1;
      r.notify_addr  = addr;
      r.notify_value = data;
      if (addr == PORT_B_DIR || addr == PORT_B_SEL || addr == PORT_B_DATA) begin
         drive_b = b_out_latch & port_image[PORT_B_DIR] & ~port_image[PORT_B_SEL] & MASK_B;
         cpu_b   = (bpins & port_image[PORT_B_SEL]) | drive_b;
         port_image[PORT_B_DATA] = cpu_b;
         r.notify_addr  = PORT_B_DATA;
         r.notify_value = cpu_b & MASK_B & ~port_image[PORT_KEY];
      end else if (addr == PORT_C_CTRL || addr == PORT_C_DATA) begin
         hi_c    = port_image[PORT_C_CTRL][7:4];
         drive_c = c_out_latch & port_image[PORT_C_CTRL][2:0] & ~hi_c[2:0] & MASK_C;
         port_image[PORT_C_DATA] = {5'b0, (cpins & hi_c[2:0]) | drive_c};
         r.notify_addr  = PORT_C_DATA;
         r.notify_value = {5'b0, drive_c};
      end else if (addr == PORT_GPO_A) begin
         // bit 2 reaches listeners only while bit 3 is set
         r.notify_value[2] = data[2] & data[3];
      end
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [7:0] got,
                                  input logic [7:0] want);
      $display("%0t: %s: got %02h want %02h", $time, what, got, want);
      mismatches++;
   endtask

   always @(posedge clock) begin
      iopf_reply_type want;
      if (reset) begin
         foreach (port_image[i]) port_image[i] = 8'h00;
         b_out_latch = 8'h00;
         c_out_latch = 3'h0;
         mismatches  = 0;
         access_outcomes.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (access_outcomes.size() == 0) begin
               report_mismatch("transaction with none pending", rsp_notify_addr, 8'h00);
            end else begin
               want = access_outcomes.pop_front();
               if (rsp_read_data !== want.read_data)
                  report_mismatch("read_data", rsp_read_data, want.read_data);
               if (rsp_notify_valid !== want.notify_valid)
                  report_mismatch("notify_valid", {7'b0, rsp_notify_valid},
                                  {7'b0, want.notify_valid});
               if (rsp_notify_addr !== want.notify_addr)
                  report_mismatch("notify_addr", rsp_notify_addr, want.notify_addr);
               if (rsp_notify_value !== want.notify_value)
                  report_mismatch("notify_value", rsp_notify_value, want.notify_value);
            end
         end
         if (req_valid && !req_stall)
            access_outcomes.push_back(port_access(req_op, req_port_addr, req_write_data,
                                                  req_gpio_b_pins, req_gpio_c_pins));
      end
      outstanding <= access_outcomes.size();
   end

endmodule

// ===== sim/io_port_file_with_gpio_latches_test.sv =====
module io_port_file_with_gpio_latches_test;
   import iopf_pkg::*;
   import iopf_test_pkg::*;

   typedef enum logic [1:0] {FLOW_OPEN, FLOW_COIN, FLOW_HEAVY, FLOW_PERIODIC} flow_mode_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic       req_op = OP_READ;
   logic [7:0] req_port_addr = 8'h00;
   logic [7:0] req_write_data = 8'h00;
   logic [7:0] req_gpio_b_pins = 8'h00;
   logic [2:0] req_gpio_c_pins = 3'h0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [7:0] rsp_read_data;
   logic       rsp_notify_valid;
   logic [7:0] rsp_notify_addr;
   logic [7:0] rsp_notify_value;
   int         mismatches;
   int         outstanding;

   flow_mode_type flow_mode = FLOW_OPEN;
   int            flow_left = 0;
   int            burst_left = 5;

   io_port_file_with_gpio_latches u_top (.*);
   iopf_port_checker              u_chk (.*);

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (flow_left == 0) begin
         flow_mode <= flow_mode_type'($urandom_range(0, 3));
         flow_left <= $urandom_range(20, 200);
      end else begin
         flow_left <= flow_left - 1;
      end
      case (flow_mode)
         FLOW_OPEN:     rsp_stall <= 1'b0;
         FLOW_COIN:     rsp_stall <= 1'($urandom_range(0, 1));
         FLOW_HEAVY:    rsp_stall <= ($urandom_range(0, 9) < 8);
         FLOW_PERIODIC: rsp_stall <= (flow_left % 5 < 2);
         default:       rsp_stall <= 1'b0;
      endcase
   end

   task automatic send_access(input logic op, input logic [7:0] addr, input logic [7:0] data,
                              input logic [7:0] bpins, input logic [2:0] cpins);
      req_op          <= op;
      req_port_addr   <= addr;
      req_write_data  <= data;
      req_gpio_b_pins <= bpins;
      req_gpio_c_pins <= cpins;
      req_valid       <= 1'b1;
      do @(posedge clock); while (req_stall);
      burst_left--;
      if (burst_left <= 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                  : $urandom_range(1, 20);
      end
   endtask

   task automatic drain_pending();
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   initial begin : stimulus
      logic       op;
      logic [7:0] addr;
      logic [7:0] data;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_access(OP_READ,  PORT_B_DATA, 8'h00, 8'hFF, 3'h7);
      send_access(OP_READ,  8'h00,       8'h00, 8'h00, 3'h0);
      send_access(OP_WRITE, 8'h00,       8'hFF, 8'h00, 3'h0);
      send_access(OP_WRITE, 8'hFF,       8'hAA, 8'hFF, 3'h7);
      send_access(OP_READ,  8'h00,       8'h55, 8'h00, 3'h0);
      send_access(OP_READ,  8'hFF,       8'h00, 8'h00, 3'h0);
      send_access(OP_WRITE, PORT_KEY,    8'h11, 8'h00, 3'h0);
      send_access(OP_WRITE, PORT_B_DIR,  8'hFF, 8'hA5, 3'h0);
      send_access(OP_WRITE, PORT_B_SEL,  8'h0F, 8'hA5, 3'h0);
      send_access(OP_WRITE, PORT_B_DATA, 8'hFF, 8'hA5, 3'h0);
      send_access(OP_READ,  PORT_B_DIR,  8'h00, 8'h00, 3'h0);
      send_access(OP_READ,  PORT_B_SEL,  8'h00, 8'h00, 3'h0);
      send_access(OP_READ,  PORT_B_DATA, 8'h00, 8'h00, 3'h0);
      send_access(OP_WRITE, PORT_B_SEL,  8'h00, 8'hFF, 3'h0);
      send_access(OP_WRITE, PORT_C_CTRL, 8'hFF, 8'h00, 3'h5);
      send_access(OP_WRITE, PORT_C_DATA, 8'hFF, 8'h00, 3'h5);
      send_access(OP_WRITE, PORT_C_CTRL, 8'h07, 8'h00, 3'h2);
      send_access(OP_WRITE, PORT_C_CTRL, 8'h50, 8'h00, 3'h7);
      send_access(OP_READ,  PORT_C_CTRL, 8'h00, 8'h00, 3'h0);
      send_access(OP_READ,  PORT_C_DATA, 8'h00, 8'h00, 3'h0);
      send_access(OP_WRITE, PORT_GPO_A,  8'h04, 8'h00, 3'h0);
      send_access(OP_WRITE, PORT_GPO_A,  8'h0C, 8'h00, 3'h0);
      send_access(OP_WRITE, PORT_GPO_A,  8'hFF, 8'h00, 3'h0);
      send_access(OP_READ,  PORT_GPO_A,  8'h00, 8'h00, 3'h0);
      drain_pending();

      for (int n = 0; n < 1000; n++) begin
         op = $urandom_range(0, 1) ? OP_WRITE : OP_READ;
         if ($urandom_range(0, 9) < 4) begin
            case ($urandom_range(0, 6))
               0: addr = PORT_GPO_A;
               1: addr = PORT_KEY;
               2: addr = PORT_B_DIR;
               3: addr = PORT_B_SEL;
               4: addr = PORT_B_DATA;
               5: addr = PORT_C_CTRL;
               default: addr = PORT_C_DATA;
            endcase
         end else begin
            addr = 8'($urandom_range(0, 255));
         end
         data = ($urandom_range(0, 15) == 0) ? ($urandom_range(0, 1) ? 8'hFF : 8'h00)
                                             : 8'($urandom_range(0, 255));
         send_access(op, addr, data, 8'($urandom_range(0, 255)), 3'($urandom_range(0, 7)));
         if (n == 300 || n == 700)
            drain_pending();
      end

      drain_pending();
      repeat (10) @(posedge clock);
      if (mismatches == 0 && outstanding == 0)
         $display("io_port_file_with_gpio_latches_test: clean");
      else
         $display("io_port_file_with_gpio_latches_test: errors");
      $finish;
   end

   initial begin : watchdog
      #5000000;
      $display("io_port_file_with_gpio_latches_test: errors");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/iopf_pkg.sv
rtl/iopf_mem.sv
rtl/iopf_gpio.sv
rtl/io_port_file_with_gpio_latches.sv
sim/iopf_test_pkg.sv
sim/iopf_port_checker.sv
sim/io_port_file_with_gpio_latches_test.sv
